FILE: src/vfp_pkg.sv
// ----------------------------------------------------------------------------
// Video frame packetizer package
// Word layouts, register indexes and command codes shared by the packetizer.
// ----------------------------------------------------------------------------
package vfp_pkg;

    localparam int BYTES_BITS   = 24;
    localparam int INDEX_BITS   = 32;
    localparam int KIND_BITS    = 2;
    localparam int STAMP_BITS   = 48;
    localparam int PAYLOAD_BITS = 16;
    localparam int LENGTH_BITS  = 17;
    localparam int OVH_BITS     = 8;
    localparam int SEQ_BITS     = 16;
    localparam int PERIOD_BITS  = 32;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // Command codes
    localparam logic CMD_FRAME_START = 1'b0;
    localparam logic CMD_PACKET_TICK = 1'b1;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd0;
    localparam logic [1:0] REG_OVERHEAD     = 2'd1;
    localparam logic [1:0] REG_SPREAD       = 2'd2;
    localparam logic [1:0] REG_FRAME_PERIOD = 2'd3;

    // Register reset values
    localparam logic [PAYLOAD_BITS-1:0] MAX_PAYLOAD_RST  = 16'd1460;
    localparam logic [OVH_BITS-1:0]     OVERHEAD_RST     = 8'd12;
    localparam logic                    SPREAD_RST       = 1'b1;
    localparam logic [PERIOD_BITS-1:0]  FRAME_PERIOD_RST = 32'd33333333;

    typedef struct packed {
        logic                  command;
        logic [BYTES_BITS-1:0] frame_bytes;
        logic [INDEX_BITS-1:0] frame_index;
        logic [KIND_BITS-1:0]  frame_kind;
        logic [STAMP_BITS-1:0] frame_stamp;
    } in_word_t;

    typedef struct packed {
        logic [LENGTH_BITS-1:0]  packet_length;
        logic [PAYLOAD_BITS-1:0] payload_bytes;
        logic [SEQ_BITS-1:0]     sequence_number;
        logic                    marker;
        logic                    fragment_start;
        logic                    fragment_end;
        logic [INDEX_BITS-1:0]   out_frame_index;
        logic [KIND_BITS-1:0]    out_frame_kind;
        logic [STAMP_BITS-1:0]   out_frame_stamp;
        logic [PERIOD_BITS-1:0]  next_gap_ticks;
    } out_word_t;

endpackage

FILE: src/vfp_serial_div.sv
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// One quotient bit per cycle, from start until done.
// ----------------------------------------------------------------------------
module vfp_serial_div #(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] numerator,
    input  logic [DEN_BITS-1:0] denominator,
    output logic                done,
    output logic [NUM_BITS-1:0] quotient,
    output logic [DEN_BITS-1:0] remainder
);

    localparam int CNT_BITS = $clog2(NUM_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(NUM_BITS - 1);

    logic [NUM_BITS-1:0] quo_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DEN_BITS:0]   partial;
    logic [DEN_BITS:0]   diff;
    logic                fits;
    logic [DEN_BITS-1:0] rem_next;

    // the numerator shifts out of the top while quotient bits shift in below
    assign partial  = {rem_reg, quo_reg[NUM_BITS-1]};
    assign diff     = partial - {1'b0, den_reg};
    assign fits     = ~diff[DEN_BITS];
    assign rem_next = fits ? diff[DEN_BITS-1:0] : partial[DEN_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= numerator;
                rem_reg  <= '0;
                den_reg  <= denominator;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: src/video_frame_packetizer.sv
// ----------------------------------------------------------------------------
// Video frame packetizer
// A frame-start word loads a frame and sends its first packet; each
// packet-tick word sends the next packet until the frame is used up. A
// packet tick is accepted in the idle state, and its packet is then loaded
// into the output register in the emit state. A frame start with spreading
// on and a non-empty frame first runs the packet count and then the packet
// spacing through a shared bit-serial divider at one quotient bit per cycle.
// Without spreading, or for an empty frame, a frame start goes straight to
// the emit state. A packet that finds the output register still full waits
// on m_ready. One word is worked on at a time; the output register lets the
// next word in while a packet still waits on m_ready.
// ----------------------------------------------------------------------------
module video_frame_packetizer #(
    parameter int SIZE_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  vfp_pkg::in_word_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output vfp_pkg::out_word_t                   m_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [vfp_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [vfp_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [vfp_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);

    localparam int LOAD_BITS = (SIZE_BITS < vfp_pkg::BYTES_BITS) ?
                               SIZE_BITS : vfp_pkg::BYTES_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_COUNT,
        ST_DIV_GAP,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [vfp_pkg::PAYLOAD_BITS-1:0] max_payload_reg;
    logic [vfp_pkg::OVH_BITS-1:0]     overhead_reg;
    logic                             spread_reg;
    logic [vfp_pkg::PERIOD_BITS-1:0]  period_reg;

    // frame state
    logic [SIZE_BITS-1:0]             bytes_remaining_reg;
    logic [SIZE_BITS-1:0]             frame_total_reg;
    logic [vfp_pkg::SEQ_BITS-1:0]     seq_reg;
    logic [vfp_pkg::INDEX_BITS-1:0]   held_index_reg;
    logic [vfp_pkg::KIND_BITS-1:0]    held_kind_reg;
    logic [vfp_pkg::STAMP_BITS-1:0]   held_stamp_reg;
    logic [vfp_pkg::PERIOD_BITS-1:0]  gap_reg;

    // output register
    logic                             m_valid_reg;
    vfp_pkg::out_word_t               m_data_reg;

    // divider hookup
    logic                             div_start_reg;
    logic [vfp_pkg::PERIOD_BITS-1:0]  div_num_reg;
    logic [SIZE_BITS-1:0]             div_den_reg;
    logic                             div_done;
    logic [vfp_pkg::PERIOD_BITS-1:0]  div_quot;
    logic [SIZE_BITS-1:0]             div_rem;

    logic                             cfg_write;
    logic                             s_accept;
    logic                             out_free;
    logic [SIZE_BITS-1:0]             load_bytes;
    logic [vfp_pkg::PAYLOAD_BITS-1:0] limit;
    logic                             take_limit;
    logic [vfp_pkg::PAYLOAD_BITS-1:0] pay;
    logic                             last_pkt;
    logic [SIZE_BITS-1:0]             pkt_count;
    vfp_pkg::out_word_t               pkt;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid & s_ready;
    assign out_free  = ~m_valid_reg | m_ready;

    assign load_bytes = SIZE_BITS'(s_data.frame_bytes[LOAD_BITS-1:0]);

    // a zero limit behaves as one byte
    assign limit      = (max_payload_reg == '0) ? vfp_pkg::PAYLOAD_BITS'(1)
                                                : max_payload_reg;
    assign take_limit = (bytes_remaining_reg >= SIZE_BITS'(limit));
    assign pay        = take_limit ? limit
                                   : bytes_remaining_reg[vfp_pkg::PAYLOAD_BITS-1:0];
    assign last_pkt   = (bytes_remaining_reg == SIZE_BITS'(pay));

    // ceil(bytes / limit) from the first pass
    assign pkt_count  = div_quot[SIZE_BITS-1:0] + SIZE_BITS'(div_rem != '0);

    always_comb begin
        pkt.packet_length   = vfp_pkg::LENGTH_BITS'(pay)
                            + vfp_pkg::LENGTH_BITS'(overhead_reg);
        pkt.payload_bytes   = pay;
        pkt.sequence_number = seq_reg;
        pkt.marker          = last_pkt;
        pkt.fragment_start  = (bytes_remaining_reg == frame_total_reg);
        pkt.fragment_end    = last_pkt;
        pkt.out_frame_index = held_index_reg;
        pkt.out_frame_kind  = held_kind_reg;
        pkt.out_frame_stamp = held_stamp_reg;
        pkt.next_gap_ticks  = last_pkt ? '0 : gap_reg;
    end

    always_comb begin
        case (paddr[3:2])
            vfp_pkg::REG_MAX_PAYLOAD:  prdata = vfp_pkg::APB_DATA_BITS'(max_payload_reg);
            vfp_pkg::REG_OVERHEAD:     prdata = vfp_pkg::APB_DATA_BITS'(overhead_reg);
            vfp_pkg::REG_SPREAD:       prdata = vfp_pkg::APB_DATA_BITS'(spread_reg);
            vfp_pkg::REG_FRAME_PERIOD: prdata = period_reg;
            default:                   prdata = '0;
        endcase
    end

    vfp_serial_div #(
        .NUM_BITS (vfp_pkg::PERIOD_BITS),
        .DEN_BITS (SIZE_BITS)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start_reg),
        .numerator   (div_num_reg),
        .denominator (div_den_reg),
        .done        (div_done),
        .quotient    (div_quot),
        .remainder   (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            max_payload_reg     <= vfp_pkg::MAX_PAYLOAD_RST;
            overhead_reg        <= vfp_pkg::OVERHEAD_RST;
            spread_reg          <= vfp_pkg::SPREAD_RST;
            period_reg          <= vfp_pkg::FRAME_PERIOD_RST;
            bytes_remaining_reg <= '0;
            frame_total_reg     <= '0;
            seq_reg             <= '0;
            held_index_reg      <= '0;
            held_kind_reg       <= '0;
            held_stamp_reg      <= '0;
            gap_reg             <= '0;
            m_valid_reg         <= 1'b0;
            div_start_reg       <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_write) begin
                case (paddr[3:2])
                    vfp_pkg::REG_MAX_PAYLOAD:
                        max_payload_reg <= pwdata[vfp_pkg::PAYLOAD_BITS-1:0];
                    vfp_pkg::REG_OVERHEAD:     overhead_reg <= pwdata[vfp_pkg::OVH_BITS-1:0];
                    vfp_pkg::REG_SPREAD:       spread_reg   <= pwdata[0];
                    vfp_pkg::REG_FRAME_PERIOD: period_reg   <= pwdata;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_data.command == vfp_pkg::CMD_FRAME_START) begin
                            bytes_remaining_reg <= load_bytes;
                            frame_total_reg     <= load_bytes;
                            held_index_reg      <= s_data.frame_index;
                            held_kind_reg       <= s_data.frame_kind;
                            held_stamp_reg      <= s_data.frame_stamp;
                            if (spread_reg && (load_bytes != '0)) begin
                                div_start_reg <= 1'b1;
                                div_num_reg   <= vfp_pkg::PERIOD_BITS'(load_bytes);
                                div_den_reg   <= SIZE_BITS'(limit);
                                state_reg     <= ST_DIV_COUNT;
                            end else begin
                                gap_reg   <= '0;
                                state_reg <= ST_EMIT;
                            end
                        end else if (bytes_remaining_reg != '0) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_DIV_COUNT: begin
                    if (div_done) begin
                        div_start_reg <= 1'b1;
                        div_num_reg   <= period_reg;
                        div_den_reg   <= pkt_count;
                        state_reg     <= ST_DIV_GAP;
                    end
                end
                ST_DIV_GAP: begin
                    if (div_done) begin
                        gap_reg   <= div_quot;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg         <= 1'b1;
                        m_data_reg          <= pkt;
                        bytes_remaining_reg <= bytes_remaining_reg - SIZE_BITS'(pay);
                        seq_reg             <= seq_reg + vfp_pkg::SEQ_BITS'(1);
                        state_reg           <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_rem_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_remaining_reg <= frame_total_reg)
        else $error("bytes remaining above frame total");

    a_frame_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_data.command == vfp_pkg::CMD_FRAME_START))
        |=> (bytes_remaining_reg == frame_total_reg) && (state_reg != ST_IDLE))
        else $error("frame start not loaded");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> ((state_reg == ST_DIV_COUNT) || (state_reg == ST_DIV_GAP)))
        else $error("divider finished outside a divide state");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && out_free) |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("packet not loaded into output register");
`endif

endmodule

FILE: test/tb_video_frame_packetizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Video frame packetizer testbench
// Feeds frame-start and packet-tick words through a valid/ready driver,
// mirrors the packetizer state to predict every packet, and checks each
// packet word field by field under random back-pressure and several register
// settings, including a long output stall.
// ----------------------------------------------------------------------------
module tb_video_frame_packetizer;

    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int MAX_TICKS    = 12;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    vfp_pkg::in_word_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    vfp_pkg::out_word_t m_data;
    logic     psel    = 1'b0;
    logic     penable = 1'b0;
    logic     pwrite  = 1'b0;
    logic [vfp_pkg::APB_ADDR_BITS-1:0] paddr  = '0;
    logic [vfp_pkg::APB_DATA_BITS-1:0] pwdata = '0;
    logic [vfp_pkg::APB_DATA_BITS-1:0] prdata;
    logic     pready;

    // register mirror
    logic [vfp_pkg::PAYLOAD_BITS-1:0] cfg_max_payload = vfp_pkg::MAX_PAYLOAD_RST;
    logic [vfp_pkg::OVH_BITS-1:0]     cfg_overhead    = vfp_pkg::OVERHEAD_RST;
    logic                             cfg_spread      = vfp_pkg::SPREAD_RST;
    logic [vfp_pkg::PERIOD_BITS-1:0]  cfg_period      = vfp_pkg::FRAME_PERIOD_RST;

    // frame state mirror
    logic [vfp_pkg::BYTES_BITS-1:0]  bytes_left = '0;
    logic [vfp_pkg::BYTES_BITS-1:0]  frame_size = '0;
    logic [vfp_pkg::SEQ_BITS-1:0]    seq_next   = '0;
    logic [vfp_pkg::INDEX_BITS-1:0]  cur_index  = '0;
    logic [vfp_pkg::KIND_BITS-1:0]   cur_kind   = '0;
    logic [vfp_pkg::STAMP_BITS-1:0]  cur_stamp  = '0;
    logic [vfp_pkg::PERIOD_BITS-1:0] cur_gap    = '0;

    vfp_pkg::in_word_t  feed[$];
    vfp_pkg::out_word_t expected_packets[$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic in_taken      = 1'b0;
    logic hold_req      = 1'b0;
    logic hold_ack      = 1'b0;
    int   hold_left     = 0;

    int errors          = 0;
    int words_taken     = 0;
    int packets_checked = 0;
    int reg_writes      = 0;
    int cycles          = 0;

    video_frame_packetizer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [vfp_pkg::STAMP_BITS-1:0] rand_stamp();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[vfp_pkg::STAMP_BITS-1:0];
    endfunction

    function automatic vfp_pkg::in_word_t frame_word(
            logic [vfp_pkg::BYTES_BITS-1:0] bytes,
            logic [vfp_pkg::INDEX_BITS-1:0] index,
            logic [vfp_pkg::KIND_BITS-1:0]  kind,
            logic [vfp_pkg::STAMP_BITS-1:0] stamp);
        vfp_pkg::in_word_t w;
        w.command     = vfp_pkg::CMD_FRAME_START;
        w.frame_bytes = bytes;
        w.frame_index = index;
        w.frame_kind  = kind;
        w.frame_stamp = stamp;
        return w;
    endfunction

    // frame fields on a tick are don't-care, so they are randomised
    function automatic vfp_pkg::in_word_t tick_word();
        vfp_pkg::in_word_t w;
        w.command     = vfp_pkg::CMD_PACKET_TICK;
        w.frame_bytes = vfp_pkg::BYTES_BITS'($urandom());
        w.frame_index = $urandom();
        w.frame_kind  = vfp_pkg::KIND_BITS'($urandom());
        w.frame_stamp = rand_stamp();
        return w;
    endfunction

    task automatic queue_word(vfp_pkg::in_word_t w);
        feed.insert(feed.size(), w);
    endtask

    task automatic queue_ticks(int n);
        for (int i = 0; i < n; i++) queue_word(tick_word());
    endtask

    // mirror of the packetizer: updates frame state and queues the packet due
    task automatic accept_word(vfp_pkg::in_word_t w);
        logic [16:0]                    limit;
        logic [vfp_pkg::BYTES_BITS-1:0] pay;
        logic                           last;
        longint unsigned                count;
        vfp_pkg::out_word_t             p;
        limit = (cfg_max_payload == '0) ? 17'd1 : {1'b0, cfg_max_payload};
        if (w.command == vfp_pkg::CMD_FRAME_START) begin
            frame_size = w.frame_bytes;
            bytes_left = w.frame_bytes;
            cur_index  = w.frame_index;
            cur_kind   = w.frame_kind;
            cur_stamp  = w.frame_stamp;
            if (cfg_spread && w.frame_bytes != '0) begin
                count   = (64'(w.frame_bytes) + 64'(limit) - 64'd1) / 64'(limit);
                cur_gap = vfp_pkg::PERIOD_BITS'(64'(cfg_period) / count);
            end else begin
                cur_gap = '0;
            end
        end else if (bytes_left == '0) begin
            return;
        end
        pay  = (bytes_left >= limit) ? vfp_pkg::BYTES_BITS'(limit) : bytes_left;
        last = (bytes_left == pay);
        p.packet_length   = {1'b0, pay[vfp_pkg::PAYLOAD_BITS-1:0]}
                          + vfp_pkg::LENGTH_BITS'(cfg_overhead);
        p.payload_bytes   = pay[vfp_pkg::PAYLOAD_BITS-1:0];
        p.sequence_number = seq_next;
        p.marker          = last;
        p.fragment_start  = (bytes_left == frame_size);
        p.fragment_end    = last;
        p.out_frame_index = cur_index;
        p.out_frame_kind  = cur_kind;
        p.out_frame_stamp = cur_stamp;
        p.next_gap_ticks  = last ? '0 : cur_gap;
        expected_packets.insert(expected_packets.size(), p);
        bytes_left = bytes_left - pay;
        seq_next   = seq_next + vfp_pkg::SEQ_BITS'(1);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("Mismatch on %s (packet %0d): expected %0h, got %0h",
                         name, packets_checked, want, got);
        end
    endtask

    task automatic check_packet(vfp_pkg::out_word_t got);
        vfp_pkg::out_word_t want;
        if (expected_packets.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("Unexpected packet word: %h", got);
            return;
        end
        want = expected_packets.pop_front();
        check_field("packet_length",   64'(want.packet_length),   64'(got.packet_length));
        check_field("payload_bytes",   64'(want.payload_bytes),   64'(got.payload_bytes));
        check_field("sequence_number", 64'(want.sequence_number),
                    64'(got.sequence_number));
        check_field("marker",          64'(want.marker),          64'(got.marker));
        check_field("fragment_start",  64'(want.fragment_start),  64'(got.fragment_start));
        check_field("fragment_end",    64'(want.fragment_end),    64'(got.fragment_end));
        check_field("out_frame_index", 64'(want.out_frame_index),
                    64'(got.out_frame_index));
        check_field("out_frame_kind",  64'(want.out_frame_kind),  64'(got.out_frame_kind));
        check_field("out_frame_stamp", 64'(want.out_frame_stamp),
                    64'(got.out_frame_stamp));
        check_field("next_gap_ticks",  64'(want.next_gap_ticks),  64'(got.next_gap_ticks));
        packets_checked++;
    endtask

    // monitor: packets out are checked before the word taken at the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_packet(m_data);
            if (s_valid && s_ready) begin
                accept_word(s_data);
                words_taken++;
            end
        end
        in_taken <= aresetn && s_valid && s_ready;
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= feed.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off whenever hold_req toggles
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // APB write followed by a read-back of the same register
    task automatic set_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] want;
        logic [31:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            vfp_pkg::REG_MAX_PAYLOAD:  cfg_max_payload = value[vfp_pkg::PAYLOAD_BITS-1:0];
            vfp_pkg::REG_OVERHEAD:     cfg_overhead    = value[vfp_pkg::OVH_BITS-1:0];
            vfp_pkg::REG_SPREAD:       cfg_spread      = value[0];
            vfp_pkg::REG_FRAME_PERIOD: cfg_period      = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            vfp_pkg::REG_MAX_PAYLOAD:  want = 32'(cfg_max_payload);
            vfp_pkg::REG_OVERHEAD:     want = 32'(cfg_overhead);
            vfp_pkg::REG_SPREAD:       want = 32'(cfg_spread);
            default:                   want = cfg_period;
        endcase
        check_field("register read-back", 64'(want), 64'(got));
    endtask

    task automatic set_config(logic [15:0] mp, logic [7:0] ovh, logic spread,
                              logic [31:0] period);
        set_reg(vfp_pkg::REG_MAX_PAYLOAD, 32'(mp));
        set_reg(vfp_pkg::REG_OVERHEAD, 32'(ovh));
        set_reg(vfp_pkg::REG_SPREAD, 32'(spread));
        set_reg(vfp_pkg::REG_FRAME_PERIOD, period);
    endtask

    // everything taken and answered, then let any idle tick clear the block
    task automatic drain();
        while (feed.size() != 0 || s_valid || expected_packets.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // mostly whole frames of random size, some cut short, some with stray ticks
    task automatic plan_random(int n);
        int              made;
        int              r;
        int              ticks;
        longint unsigned limit;
        longint unsigned packets;
        logic [vfp_pkg::BYTES_BITS-1:0] bytes;
        made  = 0;
        limit = (cfg_max_payload == '0) ? 64'd1 : 64'(cfg_max_payload);
        while (made < n) begin
            r = $urandom_range(99);
            if (r < 8) begin
                queue_word(tick_word());
                made++;
            end else begin
                r = $urandom_range(99);
                if (r < 5)       bytes = '0;
                else if (r < 60) bytes = vfp_pkg::BYTES_BITS'($urandom_range(1, 32'(3 * limit)));
                else if (r < 75) bytes = vfp_pkg::BYTES_BITS'($urandom_range(1, 32'(limit)));
                else             bytes = vfp_pkg::BYTES_BITS'($urandom());
                packets = (bytes == '0) ? 64'd1 : (64'(bytes) + limit - 64'd1) / limit;
                ticks   = int'(packets - 64'd1);
                r = $urandom_range(99);
                if (r < 15 && ticks > 0) ticks = int'($urandom_range(0, ticks - 1));
                else if (r < 30)         ticks = ticks + int'($urandom_range(1, 2));
                if (ticks > MAX_TICKS)   ticks = int'($urandom_range(0, MAX_TICKS));
                queue_word(frame_word(bytes, $urandom(),
                                      vfp_pkg::KIND_BITS'($urandom_range(3)),
                                      rand_stamp()));
                queue_ticks(ticks);
                made += 1 + ticks;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset settings
        send_idle_pct = 19;
        recv_idle_pct = 63;
        queue_word(tick_word());                              // tick with no frame
        queue_word(frame_word('0, '0, 2'd0, '0));             // empty frame
        queue_word(tick_word());
        queue_word(frame_word(24'd1, '1, 2'd3, '1));
        queue_word(frame_word(24'd3000, 32'd7, 2'd1, 48'd1000));
        queue_ticks(3);
        queue_word(frame_word(24'd1460, 32'd8, 2'd2, 48'd2000));
        queue_ticks(1);
        queue_word(frame_word('1, $urandom(), 2'd3, rand_stamp()));
        queue_ticks(2);
        queue_word(frame_word(24'd2921, 32'd9, 2'd0, 48'd3000));  // replaces the rest
        queue_ticks(2);
        drain();

        set_reg(vfp_pkg::REG_SPREAD, 32'd0);
        queue_word(frame_word(24'd4000, 32'd10, 2'd2, 48'd4000));
        queue_ticks(3);
        drain();

        set_config(16'hFFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        queue_word(frame_word('1, 32'd11, 2'd1, rand_stamp()));
        queue_ticks(2);
        drain();
        set_config(16'd0, 8'd0, 1'b1, 32'd1);
        queue_word(frame_word(24'd3, 32'd12, 2'd3, rand_stamp()));
        queue_ticks(3);
        drain();

        // random, sender idling lightly and receiver heavily
        set_config(16'($urandom_range(64, 1500)), 8'($urandom_range(255)), 1'b1,
                   $urandom());
        plan_random(280);
        drain();
        set_config(16'd0, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        plan_random(280);
        drain();

        // random, the other way round
        send_idle_pct = 63;
        recv_idle_pct = 19;
        set_config(16'hFFFF, 8'd0, 1'b0, 32'd1);
        plan_random(280);
        drain();
        set_config(16'($urandom_range(1, 65507)), 8'($urandom_range(255)), 1'b1,
                   $urandom());
        plan_random(280);
        drain();

        // random, no idling; then a long output stall while words keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(16'd1, 8'($urandom_range(255)), 1'b1, $urandom());
        plan_random(280);
        drain();
        set_config(16'($urandom_range(100, 3000)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), $urandom());
        plan_random(280);
        @(posedge aclk);
        hold_req = ~hold_req;
        drain();

        if (expected_packets.size() != 0) begin
            errors += expected_packets.size();
            $display("%0d expected packets never arrived", expected_packets.size());
        end
        $display("Covered %0d input words and %0d checked packets over %0d register writes,",
                 words_taken, packets_checked, reg_writes);
        $display("with empty, cut-short and replaced frames, a long stall and three idling mixes.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
